@@ hw/rtl/lztst_pkg.sv @@
// Package for the LZ token sequence transcoder.
// Holds the queue item and status types, field widths, constants and the
// bucket helper functions; depends on nothing.
`default_nettype none

package lztst_pkg;

    // Field widths
    localparam int unsigned TokW   = 18;
    localparam int unsigned ExtraW = 17;
    localparam int unsigned CodeW  = 5;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned SlotW  = 2;

    // Coding constants
    localparam logic [TokW-1:0]  MinMatch    = 18'd4;
    localparam logic [CodeW-1:0] RepeatDepth = 5'd3;
    localparam logic [TokW-1:0]  RecentInit0 = 18'd1;
    localparam logic [TokW-1:0]  RecentInit1 = 18'd2;
    localparam logic [TokW-1:0]  RecentInit2 = 18'd3;
    localparam logic [TokW-1:0]  PendingMax  = 18'h3FFFF;

    // Record kinds
    localparam logic KindLiteral  = 1'b0;
    localparam logic KindSequence = 1'b1;

    // Repeat slots
    localparam logic [SlotW-1:0] Slot0 = 2'd0;
    localparam logic [SlotW-1:0] Slot1 = 2'd1;
    localparam logic [SlotW-1:0] Slot2 = 2'd2;

    // Classified token, as held in the queue
    typedef struct packed {
        logic             kind;
        logic [ByteW-1:0] lit;
        logic [TokW-1:0]  litrun;
        logic [TokW-1:0]  mval;
        logic             rep_hit;
        logic [SlotW-1:0] slot;
        logic [TokW-1:0]  dval;
    } t_item;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Bit length of v, 0 for v = 0
    function automatic logic [CodeW-1:0] bit_bucket(input logic [TokW-1:0] v);
        logic [CodeW-1:0] b;
        b = '0;
        for (int i = 0; i < TokW; i++) begin
            if (v[i]) begin
                b = CodeW'(i + 1);
            end
        end
        return b;
    endfunction

    // Bits of v below its leading one, 0 for bucket 0
    function automatic logic [ExtraW-1:0] bucket_extra(input logic [TokW-1:0]  v,
                                                       input logic [CodeW-1:0] b);
        logic [TokW-1:0] t;
        t = v;
        if (b != '0) begin
            t[b - 5'd1] = 1'b0;
        end
        return t[ExtraW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lztst_front.sv @@
// Front end of the LZ token sequence transcoder: accepts tokens, keeps the
// recent-offset cache and pending literal count, pushes classified items.
// Depends on lztst_pkg.
`default_nettype none

module lztst_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic                            i_start_of_block,
    input  wire logic [lztst_pkg::TokW-1:0]      i_token_distance,
    input  wire logic [lztst_pkg::TokW-1:0]      i_token_length_or_byte,
    input  wire lztst_pkg::t_queue_status        i_qstat,
    output logic                                 o_stall,
    output logic                                 o_push,
    output lztst_pkg::t_item                     o_item
);

    logic [lztst_pkg::TokW-1:0] r_recent0, r_recent1, r_recent2;
    logic [lztst_pkg::TokW-1:0] n_recent0, n_recent1, n_recent2;
    logic [lztst_pkg::TokW-1:0] r_pending, n_pending;
    logic [lztst_pkg::TokW-1:0] cur0, cur1, cur2, cur_pend;
    logic                       is_lit, hit0, hit1, hit2, take;

    assign o_stall = i_qstat.full;
    assign take    = i_valid && !i_qstat.full;
    assign o_push  = take;

    // Apply start-of-block before the token
    always_comb begin
        if (i_start_of_block) begin
            cur0     = lztst_pkg::RecentInit0;
            cur1     = lztst_pkg::RecentInit1;
            cur2     = lztst_pkg::RecentInit2;
            cur_pend = '0;
        end else begin
            cur0     = r_recent0;
            cur1     = r_recent1;
            cur2     = r_recent2;
            cur_pend = r_pending;
        end
    end

    assign is_lit = (i_token_distance == '0);
    assign hit0   = (i_token_distance == cur0);
    assign hit1   = (i_token_distance == cur1);
    assign hit2   = (i_token_distance == cur2);

    // Classify the token and work out the next cache contents
    always_comb begin
        o_item         = '0;
        o_item.lit     = i_token_length_or_byte[lztst_pkg::ByteW-1:0];
        o_item.litrun  = cur_pend;
        o_item.dval    = i_token_distance - 18'd1;
        o_item.mval    = (i_token_length_or_byte >= lztst_pkg::MinMatch)
                       ? i_token_length_or_byte - lztst_pkg::MinMatch : '0;
        n_recent0      = cur0;
        n_recent1      = cur1;
        n_recent2      = cur2;
        n_pending      = cur_pend;
        if (is_lit) begin
            o_item.kind = lztst_pkg::KindLiteral;
            if (cur_pend != lztst_pkg::PendingMax) begin
                n_pending = cur_pend + 18'd1;
            end
        end else begin
            o_item.kind = lztst_pkg::KindSequence;
            n_pending   = '0;
            n_recent0   = i_token_distance;
            if (hit0) begin
                o_item.rep_hit = 1'b1;
                o_item.slot    = lztst_pkg::Slot0;
            end else if (hit1) begin
                o_item.rep_hit = 1'b1;
                o_item.slot    = lztst_pkg::Slot1;
                n_recent1      = cur0;
            end else if (hit2) begin
                o_item.rep_hit = 1'b1;
                o_item.slot    = lztst_pkg::Slot2;
                n_recent1      = cur0;
                n_recent2      = cur1;
            end else begin
                n_recent1 = cur0;
                n_recent2 = cur1;
            end
        end
    end

    // Advance cache and count on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent0 <= lztst_pkg::RecentInit0;
            r_recent1 <= lztst_pkg::RecentInit1;
            r_recent2 <= lztst_pkg::RecentInit2;
            r_pending <= '0;
        end else if (take) begin
            r_recent0 <= n_recent0;
            r_recent1 <= n_recent1;
            r_recent2 <= n_recent2;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lztst_queue.sv @@
// Short queue of classified items between front and back.
// Depends on lztst_pkg.
`default_nettype none

module lztst_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire lztst_pkg::t_item          i_item,
    input  wire logic                      i_pop,
    output lztst_pkg::t_item               o_head,
    output lztst_pkg::t_queue_status       o_stat
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    lztst_pkg::t_item r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [CntW-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == CntW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lztst_back.sv @@
// Back end of the LZ token sequence transcoder: turns queued items into
// bucket codes and extra bits and holds them in the output register.
// Depends on lztst_pkg.
`default_nettype none

module lztst_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lztst_pkg::t_item                   i_head,
    input  wire lztst_pkg::t_queue_status           i_qstat,
    output logic                                    o_pop,
    input  wire logic                               i_stall,
    output logic                                    o_valid,
    output logic                                    o_record_kind,
    output logic [lztst_pkg::ByteW-1:0]             o_literal_value,
    output logic [lztst_pkg::CodeW-1:0]             o_litrun_code,
    output logic [lztst_pkg::ExtraW-1:0]            o_litrun_extra,
    output logic [lztst_pkg::CodeW-1:0]             o_matchlen_code,
    output logic [lztst_pkg::ExtraW-1:0]            o_matchlen_extra,
    output logic [lztst_pkg::CodeW-1:0]             o_offset_code,
    output logic [lztst_pkg::ExtraW-1:0]            o_offset_extra
);

    logic                          r_valid;
    logic                          r_kind;
    logic [lztst_pkg::ByteW-1:0]   r_lit;
    logic [lztst_pkg::CodeW-1:0]   r_lcode, r_mcode, r_ocode;
    logic [lztst_pkg::ExtraW-1:0]  r_lextra, r_mextra, r_oextra;
    logic                          n_kind;
    logic [lztst_pkg::ByteW-1:0]   n_lit;
    logic [lztst_pkg::CodeW-1:0]   n_lcode, n_mcode, n_ocode;
    logic [lztst_pkg::ExtraW-1:0]  n_lextra, n_mextra, n_oextra;
    logic [lztst_pkg::CodeW-1:0]   lb, mb, db;
    logic                          load;

    assign load  = !i_qstat.empty && (!r_valid || !i_stall);
    assign o_pop = load;

    assign lb = lztst_pkg::bit_bucket(i_head.litrun);
    assign mb = lztst_pkg::bit_bucket(i_head.mval);
    assign db = lztst_pkg::bit_bucket(i_head.dval);

    // Build the record fields
    always_comb begin
        n_kind   = i_head.kind;
        n_lit    = '0;
        n_lcode  = '0;
        n_lextra = '0;
        n_mcode  = '0;
        n_mextra = '0;
        n_ocode  = '0;
        n_oextra = '0;
        if (i_head.kind == lztst_pkg::KindLiteral) begin
            n_lit = i_head.lit;
        end else begin
            n_lcode  = lb;
            n_lextra = lztst_pkg::bucket_extra(i_head.litrun, lb);
            n_mcode  = mb;
            n_mextra = lztst_pkg::bucket_extra(i_head.mval, mb);
            if (i_head.rep_hit) begin
                n_ocode = lztst_pkg::CodeW'(i_head.slot);
            end else begin
                n_ocode  = lztst_pkg::RepeatDepth + db;
                n_oextra = lztst_pkg::bucket_extra(i_head.dval, db);
            end
        end
    end

    // Hold the output until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= n_kind;
            r_lit    <= n_lit;
            r_lcode  <= n_lcode;
            r_lextra <= n_lextra;
            r_mcode  <= n_mcode;
            r_mextra <= n_mextra;
            r_ocode  <= n_ocode;
            r_oextra <= n_oextra;
        end
    end

    assign o_valid          = r_valid;
    assign o_record_kind    = r_kind;
    assign o_literal_value  = r_lit;
    assign o_litrun_code    = r_lcode;
    assign o_litrun_extra   = r_lextra;
    assign o_matchlen_code  = r_mcode;
    assign o_matchlen_extra = r_mextra;
    assign o_offset_code    = r_ocode;
    assign o_offset_extra   = r_oextra;

endmodule

`default_nettype wire

@@ hw/rtl/lz_token_sequence_transcoder_unit.sv @@
// Channel   Direction  Handshake           Payload
// token     in         i_valid / o_stall   start_of_block, token_distance, token_length_or_byte
// record    out        o_valid / i_stall   kind, literal, litrun, matchlen, offset codes/extras
//
// One token per cycle sustained while o_stall is low. A record passes through the queue
// and is then held in the output register, from which it transfers at an edge
// where i_stall is low.
// The front updates the recent-offset cache and literal count in the cycle of
// the transfer, so consecutive tokens see each other's effect with no bubble.
// Reset (synchronous, active low) empties the queue and output register and
// loads the cache with 1, 2, 3. A stalled output fills the queue; o_stall
// rises only when the queue is full.
// Top level; instantiates lztst_front, lztst_queue and lztst_back, uses lztst_pkg.
`default_nettype none

module lz_token_sequence_transcoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_start_of_block,
    input  wire logic [lztst_pkg::TokW-1:0]          i_token_distance,
    input  wire logic [lztst_pkg::TokW-1:0]          i_token_length_or_byte,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_record_kind,
    output logic [lztst_pkg::ByteW-1:0]              o_literal_value,
    output logic [lztst_pkg::CodeW-1:0]              o_litrun_code,
    output logic [lztst_pkg::ExtraW-1:0]             o_litrun_extra,
    output logic [lztst_pkg::CodeW-1:0]              o_matchlen_code,
    output logic [lztst_pkg::ExtraW-1:0]             o_matchlen_extra,
    output logic [lztst_pkg::CodeW-1:0]              o_offset_code,
    output logic [lztst_pkg::ExtraW-1:0]             o_offset_extra
);

    lztst_pkg::t_item          push_item, head_item;
    lztst_pkg::t_queue_status  qstat;
    logic                      push, pop;

    lztst_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .i_start_of_block       (i_start_of_block),
        .i_token_distance       (i_token_distance),
        .i_token_length_or_byte (i_token_length_or_byte),
        .i_qstat                (qstat),
        .o_stall                (o_stall),
        .o_push                 (push),
        .o_item                 (push_item)
    );

    lztst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (qstat)
    );

    lztst_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_item),
        .i_qstat          (qstat),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_record_kind    (o_record_kind),
        .o_literal_value  (o_literal_value),
        .o_litrun_code    (o_litrun_code),
        .o_litrun_extra   (o_litrun_extra),
        .o_matchlen_code  (o_matchlen_code),
        .o_matchlen_extra (o_matchlen_extra),
        .o_offset_code    (o_offset_code),
        .o_offset_extra   (o_offset_extra)
    );

endmodule

`default_nettype wire
